// File: hw/rtl/bottom_up_merge_sorter_core_defines.svh
// assertion macros for the bottom-up merge sorter
// no dependencies; included by the modules that check their own logic
`ifndef BOTTOM_UP_MERGE_SORTER_CORE_DEFINES_SVH
`define BOTTOM_UP_MERGE_SORTER_CORE_DEFINES_SVH

// clocked assertion, switched off while reset is held
`define BUMS_ASSERT_CLK(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// same, on the usual clk and rst_n of the module
`define BUMS_ASSERT(lbl, prop, msg) `BUMS_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

// File: hw/rtl/bums_pkg.sv
// shared types and defaults for the bottom-up merge sorter
// no dependencies
package bums_pkg;

  localparam int FIELD_W        = 32;
  localparam int MAX_ITEMS_DEF  = 64;
  localparam int DATA_WIDTH_DEF = 32;

  typedef struct packed {
    logic signed [FIELD_W-1:0] value;
    logic                      last;
  } bums_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] value_res;
    logic                      last_res;
    logic                      overflowed;
  } bums_out_t;

endpackage

// File: hw/rtl/bottom_up_merge_sorter_core.sv
// bottom-up merge sorter: load, ping-pong merge passes, ordered emission
// depends on bums_pkg and bottom_up_merge_sorter_core_defines.svh
//
//  channel | direction | handshake            | payload
//  in_     | request   | in_valid / in_ready   | bums_in_t  (value, last)
//  out_    | result    | out_valid / out_ready | bums_out_t (value_res, last_res, overflowed)
//
// loading takes one cycle per request; a request marked last starts the sort
// sorting n elements takes ceil(log2 n) passes: a prime step that primes the registered
//   read ports of the source buffer, then one merge step per cycle through the shared
//   compare unit
// emission streams the sorted buffer out and holds while the result side stalls
// reset (rst_n, synchronous) clears control only; the buffers are never cleared
// a stalled result holds in the output register; the next set loads behind it
`include "bottom_up_merge_sorter_core_defines.svh"

module bottom_up_merge_sorter_core
  import bums_pkg::*;
#(
  parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  bums_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output bums_out_t out_data
);

  localparam int AW = $clog2(MAX_ITEMS);       // buffer address
  localparam int CW = $clog2(MAX_ITEMS + 1);   // count, holds MAX_ITEMS itself
  localparam int WW = CW + 1;                  // run width
  localparam int SW = CW + 2;                  // run bound sums before clamping

  typedef logic [DATA_WIDTH-1:0] word_t;

  // sequencer, one-hot
  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,   // collecting elements
    ST_PRIME = 4'b0010,   // set up first run of a pass, issue reads
    ST_MERGE = 4'b0100,   // one merged element per cycle
    ST_EMIT  = 4'b1000    // stream the sorted buffer out
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;       // elements held in this set
  logic          ovf_r, ovf_nxt;       // element dropped in this set
  logic          src_r, src_nxt;       // 0: primary buffer is the source
  logic [WW-1:0] w_r, w_nxt;           // current run width
  logic [CW-1:0] a_r, a_nxt;           // left run head
  logic [CW-1:0] b_r, b_nxt;           // right run head
  logic [CW-1:0] mid_r, mid_nxt;       // end of left run
  logic [CW-1:0] hi_r, hi_nxt;         // end of right run
  logic [CW-1:0] k_r, k_nxt;           // destination index
  bums_out_t     out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  // ping-pong buffers, each with one write and two registered read ports
  word_t         prim_mem_r [MAX_ITEMS];
  word_t         scr_mem_r  [MAX_ITEMS];
  word_t         da0_r, db0_r, da1_r, db1_r;
  logic          we0, we1;
  logic [AW-1:0] wr_addr;
  word_t         wr_data;
  logic [AW-1:0] rd_a_addr, rd_b_addr;

  word_t         da, db;
  logic          take_b;
  logic          out_load;
  logic [SW-1:0] n_s, w_s, lo_mid_s, lo_hi_s, nx_mid_s, nx_hi_s;

  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // heads of the two runs, from whichever buffer is the source this pass
  assign da = src_r ? da1_r : da0_r;
  assign db = src_r ? db1_r : db0_r;

  // take the right head only while it exists and is strictly smaller, keeps ties stable
  assign take_b = (b_r < hi_r) && ((a_r >= mid_r) || ($signed(db) < $signed(da)));

  assign out_load = !out_valid_r || out_ready;

  // run bounds, clamped to the element count
  assign n_s      = SW'(cnt_r);
  assign w_s      = SW'(w_r);
  assign lo_mid_s = (w_s < n_s) ? w_s : n_s;
  assign lo_hi_s  = ((w_s << 1) < n_s) ? (w_s << 1) : n_s;
  assign nx_mid_s = ((SW'(hi_r) + w_s) < n_s) ? (SW'(hi_r) + w_s) : n_s;
  assign nx_hi_s  = ((SW'(hi_r) + (w_s << 1)) < n_s) ? (SW'(hi_r) + (w_s << 1)) : n_s;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    src_nxt       = src_r;
    w_nxt         = w_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    mid_nxt       = mid_r;
    hi_nxt        = hi_r;
    k_nxt         = k_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    we0           = 1'b0;
    we1           = 1'b0;
    wr_addr       = k_r[AW-1:0];
    wr_data       = take_b ? db : da;

    unique case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          if (cnt_r < CW'(MAX_ITEMS)) begin
            we0     = 1'b1;
            wr_addr = cnt_r[AW-1:0];
            wr_data = DATA_WIDTH'(in_data.value);
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last) begin
            w_nxt     = WW'(1);
            src_nxt   = 1'b0;
            state_nxt = ST_PRIME;
          end
        end
      end

      ST_PRIME: begin
        // first run of the pass, or the emission start once runs span the set
        a_nxt   = '0;
        k_nxt   = '0;
        mid_nxt = CW'(lo_mid_s);
        b_nxt   = CW'(lo_mid_s);
        hi_nxt  = CW'(lo_hi_s);
        if (w_s >= n_s) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_MERGE;
        end
      end

      ST_MERGE: begin
        we0   = src_r;
        we1   = !src_r;
        k_nxt = k_r + CW'(1);
        if (take_b) begin
          b_nxt = b_r + CW'(1);
        end else begin
          a_nxt = a_r + CW'(1);
        end
        if ((k_r + CW'(1)) == hi_r) begin
          if (hi_r == cnt_r) begin
            // pass complete: swap buffers, double the width
            src_nxt   = !src_r;
            w_nxt     = w_r << 1;
            state_nxt = ST_PRIME;
          end else begin
            // next pair of runs; a lone trailing run merges with an empty partner
            a_nxt   = hi_r;
            mid_nxt = CW'(nx_mid_s);
            b_nxt   = CW'(nx_mid_s);
            hi_nxt  = CW'(nx_hi_s);
          end
        end
      end

      ST_EMIT: begin
        if (out_load) begin
          out_nxt.value_res  = FIELD_W'(da);
          out_nxt.last_res   = (a_r == (cnt_r - CW'(1)));
          out_nxt.overflowed = ovf_r;
          out_valid_nxt      = 1'b1;
          a_nxt              = a_r + CW'(1);
          if (a_r == (cnt_r - CW'(1))) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // reads follow the next head positions, so data lines up with the registers
  assign rd_a_addr = a_nxt[AW-1:0];
  assign rd_b_addr = b_nxt[AW-1:0];

  always_ff @(posedge clk) begin
    if (we0) begin
      prim_mem_r[wr_addr] <= wr_data;
    end
    da0_r <= prim_mem_r[rd_a_addr];
    db0_r <= prim_mem_r[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      scr_mem_r[wr_addr] <= wr_data;
    end
    da1_r <= scr_mem_r[rd_a_addr];
    db1_r <= scr_mem_r[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      src_r       <= 1'b0;
      w_r         <= '0;
      a_r         <= '0;
      b_r         <= '0;
      mid_r       <= '0;
      hi_r        <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      src_r       <= src_nxt;
      w_r         <= w_nxt;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      mid_r       <= mid_nxt;
      hi_r        <= hi_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // run heads stay ordered inside the set while merging
  `BUMS_ASSERT(a_run_order, (state_r == ST_MERGE) |-> (a_r <= mid_r && mid_r <= b_r && b_r <= hi_r && hi_r <= cnt_r), "merge run bounds out of order")
  // merging only happens while runs are narrower than the set
  `BUMS_ASSERT(a_width_below_count, (state_r == ST_MERGE) |-> (w_r < WW'(cnt_r)), "merge pass with run width covering the set")
  // the final result hands the block back to loading with an empty set
  `BUMS_ASSERT(a_emit_end, (state_r == ST_EMIT && out_load && a_r == (cnt_r - CW'(1))) |=> (state_r == ST_LOAD && cnt_r == '0 && !ovf_r && out_valid_r && out_r.last_res), "emission did not close the set")
  // never more elements held than the buffer size
  `BUMS_ASSERT(a_count_bound, cnt_r <= CW'(MAX_ITEMS), "element count beyond capacity")

endmodule

// File: dv/tb_top.sv
// self-checking bench for bottom_up_merge_sorter_core: a directed table, then random sets
// depends on bums_pkg and the sorter rtl; needs no files or arguments at run time
module tb_top;
  import bums_pkg::*;

  typedef logic signed [FIELD_W-1:0] elem_t;

  // how the values of one random set are drawn
  typedef enum int {VAL_FULL, VAL_NARROW, VAL_EXTREME} value_mode_t;

  // result-side stall patterns, each held for a random window
  typedef enum int {READY_ALWAYS, READY_TWO_OF_THREE, READY_HALF, READY_MOSTLY} stall_mode_t;

  // one row of the directed table; typed rows carry their own expectation
  typedef struct {
    bums_in_t  req;
    bit        typed;
    bums_out_t res;
  } stim_row_t;

  localparam int    CAPACITY     = MAX_ITEMS_DEF;
  localparam int    ITEM_TARGET  = 330;
  localparam int    LONG_HOLD    = 1500;
  localparam int    IDLE_LIMIT   = 6000;
  localparam int    DRAIN_CYCLES = 40;
  localparam elem_t ELEM_MIN     = {1'b1, {(FIELD_W-1){1'b0}}};
  localparam elem_t ELEM_MAX     = {1'b0, {(FIELD_W-1){1'b1}}};

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  bums_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  bums_out_t out_data;

  int mismatch_count = 0;

  bottom_up_merge_sorter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 8-unit clock period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // sort predictor: its own copy of the load buffer, count and drop flag
  // ---------------------------------------------------------------------------
  elem_t       pending_set [CAPACITY];
  int unsigned pending_count = 0;
  bit          drop_seen     = 1'b0;
  bums_out_t   sorted_expect_q[$];

  // stores one request and, on the marked one, queues the whole sorted set
  task automatic merge_sort_predict(bums_in_t req);
    elem_t     src [CAPACITY];
    elem_t     dst [CAPACITY];
    int        n, w, lo, mid, hi, a, b, k;
    bums_out_t res;
    // a full buffer drops the value, even on the marked request
    if (pending_count < CAPACITY) begin
      pending_set[pending_count] = req.value;
      pending_count++;
    end else begin
      drop_seen = 1'b1;
    end
    if (!req.last) return;
    n   = pending_count;
    src = pending_set;
    dst = pending_set;
    // bottom-up passes; a trailing run with no partner is a merge with an empty run,
    // i.e. a plain copy. ties take the left run first, so arrival order is kept
    for (w = 1; w < n; w = w * 2) begin
      for (lo = 0; lo < n; lo = lo + 2 * w) begin
        mid = (lo + w < n) ? lo + w : n;
        hi  = (lo + 2 * w < n) ? lo + 2 * w : n;
        a   = lo;
        b   = mid;
        for (k = lo; k < hi; k++) begin
          if (b < hi && (a >= mid || src[b] < src[a])) begin
            dst[k] = src[b];
            b++;
          end else begin
            dst[k] = src[a];
            a++;
          end
        end
      end
      src = dst;
    end
    for (k = 0; k < n; k++) begin
      res.value_res  = src[k];
      res.last_res   = (k == n - 1);
      res.overflowed = drop_seen;
      sorted_expect_q.push_back(res);
    end
    // ready for the next set
    pending_count = 0;
    drop_seen     = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // request side: bursts of random length with random gaps in between
  // ---------------------------------------------------------------------------
  int burst_left  = 0;
  int items_sent  = 0;
  bit hold_off_go = 1'b0;

  // offers one request from a falling edge, returns on a falling edge after it is taken
  task automatic send_request(bums_in_t req, bit typed, bums_out_t typed_res);
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    // accepted at this edge: work out what it causes
    if (typed) sorted_expect_q.push_back(typed_res);
    else merge_sort_predict(req);
    items_sent++;
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      // now and then a long burst, so there are stretches with no gaps at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 12);
    end
  endtask

  // one whole set of n requests, the final one marked last
  task automatic send_set(int n);
    value_mode_t mode;
    bums_in_t    req;
    mode = value_mode_t'($urandom_range(0, 2));
    for (int i = 0; i < n; i++) begin
      case (mode)
        VAL_NARROW: begin
          // many duplicates around zero
          req.value = int'($urandom_range(0, 8)) - 4;
        end
        VAL_EXTREME: begin
          req.value = ($urandom_range(0, 3) == 0) ? elem_t'($urandom) :
                      ($urandom_range(0, 1) ? ELEM_MIN : ELEM_MAX);
        end
        default: begin
          req.value = $urandom;
        end
      endcase
      req.last = (i == n - 1);
      send_request(req, 1'b0, '0);
    end
  endtask

  stim_row_t directed_rows[$];

  task automatic add_row(elem_t v, bit l, bit typed, elem_t exp_v, bit exp_last, bit exp_ovf);
    stim_row_t row;
    row.req.value      = v;
    row.req.last       = l;
    row.typed          = typed;
    row.res.value_res  = exp_v;
    row.res.last_res   = exp_last;
    row.res.overflowed = exp_ovf;
    directed_rows.push_back(row);
  endtask

  initial begin : stimulus
    int set_idx;
    int roll;
    int size;
    // typed rows are one-element sets on an empty buffer: the result is the value itself
    add_row(ELEM_MIN, 1'b1, 1'b1, ELEM_MIN, 1'b1, 1'b0);
    add_row(ELEM_MAX, 1'b1, 1'b1, ELEM_MAX, 1'b1, 1'b0);
    add_row(0,        1'b1, 1'b1, 0,        1'b1, 1'b0);
    add_row(-1,       1'b1, 1'b1, -1,       1'b1, 1'b0);
    // both extremes and zero in one set
    add_row(ELEM_MAX, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(ELEM_MIN, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(0,        1'b1, 1'b0, 0, 1'b0, 1'b0);
    // equal values
    add_row(5, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(5, 1'b1, 1'b0, 0, 1'b0, 1'b0);
    // descending, odd size: trailing run copied on the first pass, merged on the last
    add_row(100,  1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(50,   1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(0,    1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(-50,  1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(-100, 1'b1, 1'b0, 0, 1'b0, 1'b0);
    // six values, duplicates and extremes mixed
    add_row(3,        1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(-1,       1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(3,        1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(-7,       1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(ELEM_MAX, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(ELEM_MIN, 1'b1, 1'b0, 0, 1'b0, 1'b0);
    // already in order
    add_row(-2, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(7,  1'b1, 1'b0, 0, 1'b0, 1'b0);

    // synchronous reset held from time zero, released on a falling edge
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
    end

    // long result-side hold-off starts here, while a full set and an overflowing one
    // keep coming, so the block backs up into the request side
    hold_off_go = 1'b1;
    send_set(CAPACITY);
    // one past capacity: the marked request itself is dropped
    send_set(CAPACITY + 1);

    set_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      if (set_idx == 4) begin
        // pause until the block has emitted everything it owes
        in_valid <= 1'b0;
        while (sorted_expect_q.size() != 0) @(negedge clk);
        @(negedge clk);
      end
      // mostly small sets, a few medium ones, now and then an overflowing one
      roll = $urandom_range(0, 29);
      if (roll == 0) size = $urandom_range(CAPACITY + 1, CAPACITY + 6);
      else if (roll < 4) size = $urandom_range(11, 40);
      else size = $urandom_range(1, 10);
      send_set(size);
      set_idx++;
    end

    in_valid <= 1'b0;
    while (sorted_expect_q.size() != 0) @(negedge clk);
    // let any stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: random stall windows, plus one long hold-off
  // ---------------------------------------------------------------------------
  initial begin : result_taker
    int          window_left;
    stall_mode_t mode;
    bit          hold_done;
    window_left = 0;
    mode        = READY_ALWAYS;
    hold_done   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_go && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (window_left == 0) begin
        mode        = stall_mode_t'($urandom_range(0, 3));
        window_left = $urandom_range(16, 80);
      end
      window_left--;
      case (mode)
        READY_ALWAYS:       out_ready <= 1'b1;
        READY_TWO_OF_THREE: out_ready <= (window_left % 3 != 0);
        READY_HALF:         out_ready <= 1'($urandom_range(0, 1));
        default:            out_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: every accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bums_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (sorted_expect_q.size() == 0) begin
        $display("%0t: result with none expected, got value %0d last %0b overflow %0b",
                 $time, out_data.value_res, out_data.last_res, out_data.overflowed);
        mismatch_count++;
      end else begin
        want = sorted_expect_q.pop_front();
        if (out_data.value_res !== want.value_res || out_data.last_res !== want.last_res ||
            out_data.overflowed !== want.overflowed) begin
          $display("%0t: expected %0d last %0b ovf %0b, got %0d last %0b ovf %0b",
                   $time, want.value_res, want.last_res, want.overflowed,
                   out_data.value_res, out_data.last_res, out_data.overflowed);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog: too long without any request or result moving ends the run
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
